>>> hw/rtl/wtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtd_pkg: shared types and constants for the word tokenizer
// Field widths, the byte classifier and the control bundle that the top
// level broadcasts to every term cell.
// ----------------------------------------------------------------------------
package wtd_pkg;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int MINLEN_W = 6;
    localparam int SLOT_W   = 5;
    localparam int WLEN_W   = 6;
    localparam int TERMS_W  = 6;

    // register reset value and lower-case fold bit
    localparam logic [MINLEN_W-1:0] MIN_LEN_RESET = 6'd4;
    localparam logic [BYTE_W-1:0]   CASE_BIT      = 8'h20;

    // step control broadcast along the row of term cells
    typedef struct packed {
        logic              step;   // stage-1 word moves to the output register
        logic              app;    // that word appended a letter
        logic              first;  // appended letter sits at position zero
        logic              add;    // finished word is new: free cell claims it
        logic              clear;  // last byte of the stream: drop all terms
        logic [BYTE_W-1:0] chr;    // lower-cased letter of that word
    } t_cell_ctl;

    // ASCII letter test, bytes above 127 are never letters
    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

>>> hw/rtl/wtd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtd_cell: one term slot of the dedup table
// Holds the letters and length of one stored term, compares the letter at
// the current word position against the broadcast letter and keeps a running
// match flag. Valid bits form a thermometer along the row: the first cell
// whose left neighbor is valid and which is not valid itself is the free one.
// ----------------------------------------------------------------------------
module wtd_cell #(
    parameter  int TERM_BYTES = 64,
    localparam int WORD_MAX   = TERM_BYTES - 1,
    localparam int AW         = $clog2(WORD_MAX),
    localparam int LEN_W      = $clog2(TERM_BYTES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_prev_valid,
    input  logic                      i_rd_en,
    input  logic                      i_wr_req,
    input  logic [AW-1:0]             i_addr,
    input  logic [wtd_pkg::BYTE_W-1:0] i_wdata,
    input  wtd_pkg::t_cell_ctl        i_ctl,
    input  logic [LEN_W-1:0]          i_len,
    output logic                      o_valid,
    output logic                      o_match
);
    import wtd_pkg::*;

    logic [BYTE_W-1:0] r_mem [WORD_MAX];
    logic [BYTE_W-1:0] r_rdata;
    logic [LEN_W-1:0]  r_len;
    logic              r_valid;
    logic              r_flag;
    logic              free;
    logic              flag_eff;

    // this cell takes the next new term
    assign free = i_prev_valid & ~r_valid;

    // letter store: the free cell gathers the word as it arrives
    always_ff @(posedge i_clk) begin
        if (i_wr_req && free) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // running match including the letter now in stage 1
    always_comb begin
        if (i_ctl.app) begin
            flag_eff = (i_ctl.first | r_flag) & (r_rdata == i_ctl.chr);
        end else begin
            flag_eff = r_flag;
        end
    end

    assign o_match = r_valid & (r_len == i_len) & flag_eff;
    assign o_valid = r_valid;

    // match flag and slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            if (i_ctl.step && i_ctl.app) begin
                r_flag <= flag_eff;
            end
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctl.add && free) begin
                r_valid <= 1'b1;
            end
        end
    end

    // stored length, written when the cell is claimed
    always_ff @(posedge i_clk) begin
        if (i_ctl.add && free) begin
            r_len <= i_len;
        end
    end

endmodule

>>> hw/rtl/word_tokenizer_with_dedup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_tokenizer_with_dedup_top: byte stream to deduplicated word terms
// Gathers lower-cased letter runs into words and checks each finished word
// against a row of term cells; new words of sufficient length are stored.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  cfg     | in        | i_cfg_we                   | i_cfg_data
//  in      | in        | i_in_valid / o_in_stall    | i_text_byte, i_stream_last
//  out     | out       | o_out_valid / i_out_stall  | o_word_ended .. o_stream_done
//
//  One word out per byte in, loaded into the output register from stage 1.
//  Bytes inside a word go at one per cycle while the output is not stalled; the
//  cell memories read the word position at accept and all cells compare in the next cycle.
//  A byte that ends a word or the stream holds the next byte back until it leaves
//  stage 1: the term commit and the term counter settle before the next byte is taken.
//  Synchronous reset clears cell valid bits and counters; no clearing pass.
//  The output register lets the next byte in while a result waits.
// ----------------------------------------------------------------------------
module word_tokenizer_with_dedup_top #(
    parameter int TERM_SLOTS = 32,
    parameter int TERM_BYTES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wtd_pkg::MINLEN_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [wtd_pkg::BYTE_W-1:0]  i_text_byte,
    input  logic                        i_stream_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_word_ended,
    output logic                        o_term_added,
    output logic                        o_term_duplicate,
    output logic [wtd_pkg::SLOT_W-1:0]  o_slot_index,
    output logic [wtd_pkg::WLEN_W-1:0]  o_word_length,
    output logic [wtd_pkg::TERMS_W-1:0] o_terms_stored,
    output logic                        o_table_full,
    output logic                        o_stream_done
);
    import wtd_pkg::*;

    localparam int WORD_MAX = TERM_BYTES - 1;
    localparam int AW       = $clog2(WORD_MAX);
    localparam int LEN_W    = $clog2(TERM_BYTES);
    localparam int IDX_W    = (TERM_SLOTS > 1) ? $clog2(TERM_SLOTS) : 1;
    localparam int TOT_W    = $clog2(TERM_SLOTS + 1);
    localparam int CMP_W    = LEN_W + MINLEN_W;

    // configuration and stream state
    logic [MINLEN_W-1:0] r_min;
    logic [LEN_W-1:0]    r_fill, n_fill;
    logic [TOT_W-1:0]    r_total, n_total;

    // stage 1: accepted byte, cell memories already read
    logic              r_s1_v;
    logic              r_s1_app;
    logic              r_s1_first;
    logic              r_s1_fin;
    logic              r_s1_last;
    logic [BYTE_W-1:0] r_s1_chr;
    logic [LEN_W-1:0]  r_s1_len;

    // output register
    logic               r_o_v;
    logic               r_word_ended;
    logic               r_term_added;
    logic               r_term_duplicate;
    logic [SLOT_W-1:0]  r_slot_index;
    logic [WLEN_W-1:0]  r_word_length;
    logic [TERMS_W-1:0] r_terms_stored;
    logic               r_table_full;
    logic               r_stream_done;

    // accept-side decode
    logic              out_en;
    logic              step;
    logic              in_ready;
    logic              accept;
    logic              active;
    logic              app;
    logic              fin;
    logic [LEN_W-1:0]  len_new;
    logic [BYTE_W-1:0] chr;

    // stage-1 resolve
    logic [TERM_SLOTS-1:0] cell_valid;
    logic [TERM_SLOTS-1:0] cell_match;
    logic [TERM_SLOTS-1:0] cell_prev;
    logic                  match_any;
    logic [IDX_W-1:0]      match_idx;
    logic                  long_word;
    logic                  add;
    logic                  dup;
    logic [TOT_W-1:0]      total_after;
    logic [IDX_W-1:0]      slot_sel;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [TOT_W+TERMS_W-1:0] total_ext;
    logic [LEN_W+WLEN_W-1:0]  len_ext;
    t_cell_ctl             ctl;

    // handshake: hold a new byte while stage 1 cannot move or holds a word- or stream-ending byte
    assign out_en     = ~r_o_v | ~i_out_stall;
    assign step       = r_s1_v & out_en;
    assign in_ready   = ~r_s1_v | (out_en & ~r_s1_fin & ~r_s1_last);
    assign accept     = i_in_valid & in_ready;
    assign o_in_stall = ~in_ready;

    // byte classification and word fill
    always_comb begin
        active  = (r_total < TOT_W'(TERM_SLOTS));
        app     = active & is_letter(i_text_byte);
        chr     = i_text_byte | CASE_BIT;
        len_new = app ? (r_fill + LEN_W'(1)) : r_fill;
        if (app) begin
            fin = (len_new == LEN_W'(WORD_MAX)) | i_stream_last;
        end else begin
            fin = active & (r_fill != '0);
        end
        if (i_stream_last || fin) begin
            n_fill = '0;
        end else begin
            n_fill = len_new;
        end
    end

    // config register and fill counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= MIN_LEN_RESET;
            r_fill <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_data;
            end
            if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

    // stage-1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (step) begin
            r_s1_v <= 1'b0;
        end
    end

    // stage-1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_app   <= app;
            r_s1_first <= (r_fill == '0);
            r_s1_fin   <= fin;
            r_s1_last  <= i_stream_last;
            r_s1_chr   <= chr;
            r_s1_len   <= len_new;
        end
    end

    // row of term cells, valid bits chained left to right
    assign cell_prev[0] = 1'b1;
    for (genvar g = 1; g < TERM_SLOTS; g++) begin : g_link
        assign cell_prev[g] = cell_valid[g-1];
    end

    for (genvar g = 0; g < TERM_SLOTS; g++) begin : g_cell
        wtd_cell #(
            .TERM_BYTES (TERM_BYTES)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prev_valid (cell_prev[g]),
            .i_rd_en      (accept),
            .i_wr_req     (accept & app),
            .i_addr       (r_fill[AW-1:0]),
            .i_wdata      (chr),
            .i_ctl        (ctl),
            .i_len        (r_s1_len),
            .o_valid      (cell_valid[g]),
            .o_match      (cell_match[g])
        );
    end

    // stored terms are distinct, so at most one cell matches
    always_comb begin
        match_idx = '0;
        for (int s = 0; s < TERM_SLOTS; s++) begin
            if (cell_match[s]) begin
                match_idx = match_idx | IDX_W'(s);
            end
        end
        match_any = |cell_match;
    end

    // term decision for the word in stage 1
    always_comb begin
        long_word   = (CMP_W'(r_s1_len) >= CMP_W'(r_min));
        add         = r_s1_fin & long_word & ~match_any;
        dup         = r_s1_fin & long_word & match_any;
        total_after = r_total + TOT_W'(add);
        if (dup) begin
            slot_sel = match_idx;
        end else if (add) begin
            slot_sel = r_total[IDX_W-1:0];
        end else begin
            slot_sel = '0;
        end
        slot_ext  = (IDX_W+SLOT_W)'(slot_sel);
        total_ext = (TOT_W+TERMS_W)'(total_after);
        len_ext   = (LEN_W+WLEN_W)'(r_s1_fin ? r_s1_len : '0);
        n_total   = r_s1_last ? '0 : total_after;

        ctl.step  = step;
        ctl.app   = r_s1_app;
        ctl.first = r_s1_first;
        ctl.add   = step & add;
        ctl.clear = step & r_s1_last;
        ctl.chr   = r_s1_chr;
    end

    // term counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_o_v   <= 1'b0;
        end else begin
            if (step) begin
                r_total <= n_total;
            end
            if (out_en) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_word_ended     <= r_s1_fin;
            r_term_added     <= add;
            r_term_duplicate <= dup;
            r_slot_index     <= slot_ext[SLOT_W-1:0];
            r_word_length    <= len_ext[WLEN_W-1:0];
            r_terms_stored   <= total_ext[TERMS_W-1:0];
            r_table_full     <= (total_after == TOT_W'(TERM_SLOTS));
            r_stream_done    <= r_s1_last;
        end
    end

    assign o_out_valid      = r_o_v;
    assign o_word_ended     = r_word_ended;
    assign o_term_added     = r_term_added;
    assign o_term_duplicate = r_term_duplicate;
    assign o_slot_index     = r_slot_index;
    assign o_word_length    = r_word_length;
    assign o_terms_stored   = r_terms_stored;
    assign o_table_full     = r_table_full;
    assign o_stream_done    = r_stream_done;

endmodule

>>> test/word_tokenizer_with_dedup_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_tokenizer_with_dedup_top_test: self-checking bench for the tokenizer
// A short directed table, then phases of random text streams, one for each
// setting of the minimum term length. Every accepted byte is run through a
// behavioral copy of the tokenizer and the expected word is queued. Output
// words are compared field by field in order. Both handshake sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module word_tokenizer_with_dedup_top_test;
    import wtd_pkg::*;

    localparam int SLOTS       = 32;
    localparam int WORD_MAX    = 63;
    localparam int VOCAB       = 6;
    localparam int PHASE_BYTES = 175;

    // one output word, in port order
    typedef struct packed {
        logic              word_ended;
        logic              term_added;
        logic              term_duplicate;
        logic [SLOT_W-1:0]  slot_index;
        logic [WLEN_W-1:0]  word_length;
        logic [TERMS_W-1:0] terms_stored;
        logic              table_full;
        logic              stream_done;
    } result_t;

    // directed row: byte, last flag, and a typed-in word where one is given
    typedef struct packed {
        logic [BYTE_W-1:0] txt;
        logic              last;
        logic              typed;
        result_t           want;
    } row_t;

    localparam result_t NOTHING = '0;

    localparam row_t DIRECTED [0:24] = '{
        // letters at the case extremes, no word yet
        '{8'h41, 1'b0, 1'b1, NOTHING},
        '{8'h5A, 1'b0, 1'b1, NOTHING},
        '{8'h61, 1'b0, 1'b0, '0},
        '{8'h7A, 1'b0, 1'b0, '0},
        // byte just below 'A' ends "azaz", new term in slot 0
        '{8'h40, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 5'd0, 6'd4, 6'd1, 1'b0, 1'b0}},
        // non-letters around the letter ranges, no pending word
        '{8'h5B, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0, 6'd0, 6'd1, 1'b0, 1'b0}},
        '{8'h60, 1'b0, 1'b0, '0},
        '{8'h7B, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        // upper-case repeat of the stored term: duplicate
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0},
        // word below the minimum length
        '{8'h62, 1'b0, 1'b0, '0},
        '{8'h43, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        // last byte is a letter: appended, then the short word ends
        '{8'h71, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd0, 6'd1, 6'd1, 1'b0, 1'b1}},
        // fresh stream, last byte is a non-letter closing a word
        '{8'h57, 1'b0, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},
        '{8'h59, 1'b0, 1'b0, '0},
        '{8'h7A, 1'b0, 1'b0, '0},
        '{8'h2E, 1'b1, 1'b0, '0}
    };

    // DUT signals, inputs known from time zero
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_we         = 1'b0;
    logic [MINLEN_W-1:0] i_cfg_data       = '0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [BYTE_W-1:0]   i_text_byte      = '0;
    logic                i_stream_last    = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic                o_word_ended;
    logic                o_term_added;
    logic                o_term_duplicate;
    logic [SLOT_W-1:0]   o_slot_index;
    logic [WLEN_W-1:0]   o_word_length;
    logic [TERMS_W-1:0]  o_terms_stored;
    logic                o_table_full;
    logic                o_stream_done;

    // tokenizer state as the bench sees it
    logic [BYTE_W-1:0]   term_text [SLOTS][WORD_MAX];
    logic [WLEN_W-1:0]   term_len  [SLOTS];
    int                  held_terms;
    logic [BYTE_W-1:0]   word_text [WORD_MAX];
    int                  word_fill;
    logic [MINLEN_W-1:0] min_len = MIN_LEN_RESET;

    // words still owed by the DUT, oldest first
    result_t             expected_words [$];
    int                  mismatches = 0;
    int                  sent_bytes = 0;

    // idling control and per-phase vocabulary of repeated words
    bit                  in_quiet  = 1'b0;
    bit                  out_quiet = 1'b0;
    logic [4:0]          vocab_idx [VOCAB][80];
    int                  vocab_len [VOCAB];

    word_tokenizer_with_dedup_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_text_byte      (i_text_byte),
        .i_stream_last    (i_stream_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_word_ended     (o_word_ended),
        .o_term_added     (o_term_added),
        .o_term_duplicate (o_term_duplicate),
        .o_slot_index     (o_slot_index),
        .o_word_length    (o_word_length),
        .o_terms_stored   (o_terms_stored),
        .o_table_full     (o_table_full),
        .o_stream_done    (o_stream_done)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit alpha(input logic [BYTE_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // close the gathered word: length, then lookup or store
    function automatic result_t close_word(input result_t r);
        int  len;
        bit  same;
        len = word_fill;
        r.word_ended  = 1'b1;
        r.word_length = len[WLEN_W-1:0];
        word_fill = 0;
        if (len < min_len) return r;
        for (int s = 0; s < held_terms; s++) begin
            if (term_len[s] == len) begin
                same = 1'b1;
                for (int k = 0; k < len; k++)
                    if (term_text[s][k] != word_text[k]) same = 1'b0;
                if (same) begin
                    r.term_duplicate = 1'b1;
                    r.slot_index     = s[SLOT_W-1:0];
                    return r;
                end
            end
        end
        if (held_terms < SLOTS) begin
            for (int k = 0; k < len; k++) term_text[held_terms][k] = word_text[k];
            term_len[held_terms] = len[WLEN_W-1:0];
            r.term_added = 1'b1;
            r.slot_index = held_terms[SLOT_W-1:0];
            held_terms++;
        end
        return r;
    endfunction

    // expected output word for one accepted byte
    function automatic result_t tokenize_byte(input logic [BYTE_W-1:0] c, input logic last);
        result_t r;
        r = '0;
        if (held_terms < SLOTS) begin
            if (alpha(c)) begin
                if (word_fill < WORD_MAX) begin
                    word_text[word_fill] = c | 8'h20;
                    word_fill++;
                end
                if (word_fill >= WORD_MAX || last) r = close_word(r);
            end else if (word_fill > 0) begin
                r = close_word(r);
            end
        end
        r.terms_stored = held_terms[TERMS_W-1:0];
        r.table_full   = (held_terms >= SLOTS);
        r.stream_done  = last;
        // last byte empties the table for the next stream
        if (last) begin
            held_terms = 0;
            word_fill  = 0;
        end
        return r;
    endfunction

    // one byte through the input handshake; valid stays up after accept
    task automatic push_byte(input logic [BYTE_W-1:0] c, input logic last,
                             input bit typed, input result_t want);
        int      gap;
        result_t r;
        gap = in_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= c;
        i_stream_last <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = tokenize_byte(c, last);
        expected_words.push_back(typed ? want : r);
        sent_bytes++;
    endtask

    // register write once the pipe has drained
    task automatic write_min_len(input logic [MINLEN_W-1:0] v);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        min_len = v;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (min_len > 20 && $urandom_range(0, 1)) return $urandom_range(60, 66);
        if (r == 0) return WORD_MAX;
        if (r == 1) return $urandom_range(55, 75);
        if (r < 4)  return $urandom_range(7, 20);
        return $urandom_range(1, 6);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_separator();
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(0, 255)); while (alpha(c));
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] mixed_case(input logic [4:0] idx);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + BYTE_W'(idx);
    endfunction

    // one stream: mostly words with separators, sometimes raw noise;
    // cut to the room left in the phase
    task automatic emit_stream(input int room);
        logic [BYTE_W-1:0] text_q [$];
        int                words;
        int                len;
        int                w;
        bit                busy;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 40)) text_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end else begin
            busy  = ($urandom_range(0, 3) == 0);
            words = busy ? $urandom_range(36, 60) : $urandom_range(1, 15);
            for (int n = 0; n < words; n++) begin
                // a crowded stream uses short fresh words so the table fills
                if (!busy && $urandom_range(0, 2) == 0) begin
                    w = $urandom_range(0, VOCAB - 1);
                    for (int k = 0; k < vocab_len[w]; k++)
                        text_q.push_back(mixed_case(vocab_idx[w][k]));
                end else begin
                    len = busy ? $urandom_range(2, 5) : pick_length();
                    repeat (len) text_q.push_back(mixed_case(5'($urandom_range(0, 25))));
                end
                // last word may end right on the final byte
                if (n < words - 1 || $urandom_range(0, 1))
                    repeat (busy ? 1 : $urandom_range(1, 3)) text_q.push_back(pick_separator());
            end
        end
        while (text_q.size() > room) void'(text_q.pop_back());
        for (int k = 0; k < text_q.size(); k++)
            push_byte(text_q[k], k == text_q.size() - 1, 1'b0, '0);
    endtask

    // one setting of the minimum length, fresh vocabulary, random streams
    task automatic run_phase(input logic [MINLEN_W-1:0] v, input bit iq, input bit oq);
        int start;
        write_min_len(v);
        in_quiet  = iq;
        out_quiet = oq;
        for (int w = 0; w < VOCAB; w++) begin
            vocab_len[w] = pick_length();
            if (vocab_len[w] > 80) vocab_len[w] = 80;
            for (int k = 0; k < vocab_len[w]; k++) vocab_idx[w][k] = 5'($urandom_range(0, 25));
        end
        start = sent_bytes;
        while (sent_bytes - start < PHASE_BYTES) emit_stream(PHASE_BYTES - (sent_bytes - start));
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // output receiver: random stall per word
    initial begin
        int hold;
        wait (i_rst_n);
        forever begin
            hold = out_quiet ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // compare every accepted output word with the oldest expectation
    always @(posedge i_clk) begin : watch_words
        result_t want;
        result_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_word_ended, o_term_added, o_term_duplicate, o_slot_index,
                   o_word_length, o_terms_stored, o_table_full, o_stream_done};
            if (expected_words.size() == 0) begin
                $error("output word with none expected");
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                cmp_field("word_ended",     8'(want.word_ended),     8'(got.word_ended));
                cmp_field("term_added",     8'(want.term_added),     8'(got.term_added));
                cmp_field("term_duplicate", 8'(want.term_duplicate), 8'(got.term_duplicate));
                cmp_field("slot_index",     8'(want.slot_index),     8'(got.slot_index));
                cmp_field("word_length",    8'(want.word_length),    8'(got.word_length));
                cmp_field("terms_stored",   8'(want.terms_stored),   8'(got.terms_stored));
                cmp_field("table_full",     8'(want.table_full),     8'(got.table_full));
                cmp_field("stream_done",    8'(want.stream_done),    8'(got.stream_done));
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // main sequence
    initial begin
        held_terms = 0;
        word_fill  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset minimum length
        for (int i = 0; i < $size(DIRECTED); i++)
            push_byte(DIRECTED[i].txt, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

        // random streams across the range of the register
        run_phase(6'd2,  1'b0, 1'b0);
        run_phase(6'd63, 1'b0, 1'b0);
        run_phase(6'd0,  1'b1, 1'b1);
        run_phase(6'd1,  1'b0, 1'b0);
        run_phase(MINLEN_W'($urandom_range(2, 62)), 1'b1, 1'b0);
        run_phase(MINLEN_W'($urandom_range(0, 63)), 1'b0, 1'b1);
        run_phase(MIN_LEN_RESET, 1'b0, 1'b0);

        // drain, then wait on to catch stray words
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
